@@ rtl/bchd_pkg.sv @@
// Package for the button combination hotkey detector: types, register codes and constants.
`default_nettype none

package bchd_pkg;

  // Fixed register file layout
  localparam int unsigned HkSlots    = 4;   // combo/time register pairs
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 36;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned BtnW       = 32;
  localparam int unsigned PlayerW    = 3;

  // Parameter defaults
  localparam int unsigned NumHotkeysDef = 4;
  localparam int unsigned NumPlayersDef = 8;

  // Register indexes: combos first, then thresholds
  localparam logic [CfgIdxW-1:0] RegComboBase = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTimeBase  = 3'd4;

  // Combo register fields
  localparam int unsigned ComboModeLsb = 32;
  localparam int unsigned ComboGlobBit = 34;
  localparam int unsigned ComboEnBit   = 35;

  // Trigger modes
  localparam logic [1:0] ModeHold    = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeTap     = 2'd2;

  // Request codes
  localparam logic [1:0] ReqReport = 2'd0;
  localparam logic [1:0] ReqGlobal = 2'd1;
  localparam logic [1:0] ReqReset  = 2'd2;

  localparam logic [BtnW-1:0] BtnNone = 32'h0000_0000;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [BtnW-1:0]    buttons;
    logic [PlayerW-1:0] player;
    logic [TimeW-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         hotkey_index;
    logic [PlayerW-1:0] player_index;
    logic               from_merged;
    logic [TimeW-1:0]   held_ms;
    logic               last;
  } out_item_t;

  // State and results carried down the cell chain
  typedef struct packed {
    logic [TimeW-1:0]                hold_start;
    logic [HkSlots-1:0]              held;
    logic [HkSlots-1:0]              fired;
    logic [BtnW-1:0]                 buttons;
    logic [TimeW-1:0]                now_ms;
    logic                            want_global;
    logic [PlayerW-1:0]              player;
    logic                            merged;
    logic [HkSlots-1:0]              fire;
    logic [HkSlots-1:0][TimeW-1:0]   held_ms;
  } tok_t;

endpackage

`default_nettype wire

@@ rtl/button_combo_hotkey_detector_unit.sv @@
// Top level of the button combination hotkey detector.
// Flow: an item runs down the chain of NumHotkeys cells and is registered in each; its
// results are registered at the chain end and follow one per cycle while out_stall_i is low.
// Throughput: one item at a time; the next is taken after the chain drains and the last
// result is taken; reset and ignored items do not enter the chain.
// Reset: asynchronous, clears configuration, per-player state and merged state.
`default_nettype none

module button_combo_hotkey_detector_unit
  import bchd_pkg::*;
#(
  parameter int unsigned NumHotkeys = NumHotkeysDef,
  parameter int unsigned NumPlayers = NumPlayersDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned PidxW = (NumPlayers > 1) ? $clog2(NumPlayers) : 1;

  // Configuration
  logic [HkSlots-1:0][CfgDataW-1:0] combo_q;
  logic [HkSlots-1:0][TimeW-1:0]    thr_q;

  // Per-player and merged state
  logic [TimeW-1:0]   start_q [NumPlayers];
  logic [HkSlots-1:0] held_q  [NumPlayers];
  logic [HkSlots-1:0] fired_q [NumPlayers];
  logic [BtnW-1:0]    mbtn_q;
  logic [TimeW-1:0]   mstart_q;
  logic [HkSlots-1:0] mheld_q, mfired_q;

  // Result walker
  logic [HkSlots-1:0]            pend_q;
  logic [HkSlots-1:0][TimeW-1:0] res_ms_q;
  logic [PlayerW-1:0]            res_pl_q;
  logic                          res_mrg_q;

  logic               in_acc, in_range, launch, out_acc, busy;
  logic [PidxW-1:0]   pidx, end_pidx;
  tok_t               tok_in;
  logic [NumHotkeys-1:0] vld;
  tok_t               tok [NumHotkeys];
  logic               vld_end;
  tok_t               tok_end;
  logic [1:0]         sel;
  logic [HkSlots-1:0] sel_oh;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_range = int'(in_item_i.player) < int'(NumPlayers);
  assign pidx     = PidxW'(in_item_i.player);
  assign launch   = in_acc && ((in_item_i.req_type == ReqReport && in_range) ||
                               in_item_i.req_type == ReqGlobal);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      combo_q <= '0;
      thr_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < RegTimeBase) begin
        combo_q[2'(cfg_idx_i - RegComboBase)] <= cfg_data_i;
      end else begin
        thr_q[2'(cfg_idx_i - RegTimeBase)] <= cfg_data_i[TimeW-1:0];
      end
    end
  end

  // Token launched into the first cell
  always_comb begin
    tok_in         = '0;
    tok_in.now_ms  = in_item_i.now_ms;
    if (in_item_i.req_type == ReqGlobal) begin
      tok_in.hold_start  = mstart_q;
      tok_in.held        = mheld_q;
      tok_in.fired       = mfired_q;
      tok_in.buttons     = mbtn_q;
      tok_in.want_global = 1'b1;
      tok_in.merged      = 1'b1;
    end else begin
      tok_in.hold_start = start_q[pidx];
      tok_in.held       = held_q[pidx];
      tok_in.fired      = fired_q[pidx];
      tok_in.buttons    = in_item_i.buttons;
      tok_in.player     = in_item_i.player;
    end
  end

  // Cell chain, one cell per hotkey
  for (genvar k = 0; k < NumHotkeys; k++) begin : g_cell
    bchd_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_valid_i((k == 0) ? launch : vld[(k == 0) ? 0 : k-1]),
      .tok_i      ((k == 0) ? tok_in : tok[(k == 0) ? 0 : k-1]),
      .combo_i    (combo_q[k]),
      .thr_i      (thr_q[k]),
      .tok_valid_o(vld[k]),
      .tok_o      (tok[k])
    );
  end

  assign vld_end  = vld[NumHotkeys-1];
  assign tok_end  = tok[NumHotkeys-1];
  assign end_pidx = PidxW'(tok_end.player);

  // Player state: reset items and write-back at the chain end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < int'(NumPlayers); p++) begin
        start_q[p] <= '0;
        held_q[p]  <= '0;
        fired_q[p] <= '0;
      end
    end else if (in_acc && in_item_i.req_type == ReqReset && in_range) begin
      start_q[pidx] <= '0;
      held_q[pidx]  <= '0;
      fired_q[pidx] <= '0;
    end else if (vld_end && !tok_end.merged) begin
      start_q[end_pidx] <= tok_end.hold_start;
      held_q[end_pidx]  <= tok_end.held;
      fired_q[end_pidx] <= tok_end.fired;
    end
  end

  // Merged state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbtn_q   <= BtnNone;
      mstart_q <= '0;
      mheld_q  <= '0;
      mfired_q <= '0;
    end else begin
      if (in_acc && in_item_i.req_type == ReqReport && in_range) begin
        mbtn_q <= mbtn_q | in_item_i.buttons;
      end else if (in_acc && in_item_i.req_type == ReqGlobal) begin
        mbtn_q <= BtnNone;
      end
      if (vld_end && tok_end.merged) begin
        mstart_q <= tok_end.hold_start;
        mheld_q  <= tok_end.held;
        mfired_q <= tok_end.fired;
      end
    end
  end

  // Result walker: lowest pending hotkey first
  always_comb begin
    sel = '0;
    for (int i = HkSlots - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign sel_oh  = HkSlots'(1) << sel;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (vld_end) begin
      pend_q <= tok_end.fire;
    end else if (out_acc) begin
      pend_q <= pend_q & ~sel_oh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_end) begin
      res_ms_q  <= tok_end.held_ms;
      res_pl_q  <= tok_end.player;
      res_mrg_q <= tok_end.merged;
    end
  end

  assign out_valid_o             = pend_q != '0;
  assign out_item_o.hotkey_index = sel;
  assign out_item_o.player_index = res_pl_q;
  assign out_item_o.from_merged  = res_mrg_q;
  assign out_item_o.held_ms      = res_ms_q[sel];
  assign out_item_o.last         = (pend_q & ~sel_oh) == '0;

  // Busy while a token is in the chain or results wait
  assign busy       = (vld != '0) || out_valid_o;
  assign in_stall_o = busy;

endmodule

`default_nettype wire

@@ rtl/bchd_cell.sv @@
// One hotkey cell: updates its combo's held/fired bits and the shared hold start, and flags fires.
`default_nettype none

module bchd_cell
  import bchd_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                tok_valid_i,
  input  wire tok_t                tok_i,
  input  wire logic [CfgDataW-1:0] combo_i,
  input  wire logic [TimeW-1:0]    thr_i,
  output logic                     tok_valid_o,
  output tok_t                     tok_o
);

  logic             vld_q;
  tok_t             tok_q, tok_d;
  logic [BtnW-1:0]  mask;
  logic [1:0]       mode;
  logic             active, match, was;
  logic [TimeW-1:0] diff;

  assign mask   = combo_i[BtnW-1:0];
  assign mode   = combo_i[ComboModeLsb+1:ComboModeLsb];
  assign active = combo_i[ComboEnBit] && (combo_i[ComboGlobBit] == tok_i.want_global);
  assign match  = (tok_i.buttons & mask) == mask;
  assign was    = tok_i.held[Idx];

  // Cell update
  always_comb begin
    tok_d = tok_i;
    diff  = tok_i.now_ms - tok_i.hold_start;
    if (active) begin
      if (match) begin
        if (!was) begin
          tok_d.hold_start = tok_i.now_ms;
          tok_d.fired[Idx] = 1'b0;
        end
        tok_d.held[Idx] = 1'b1;
        diff = tok_i.now_ms - tok_d.hold_start;
        if (mode == ModeHold && !tok_d.fired[Idx] && diff >= thr_i) begin
          tok_d.fire[Idx]    = 1'b1;
          tok_d.held_ms[Idx] = diff;
          tok_d.fired[Idx]   = 1'b1;
        end
      end else begin
        if (was && ((mode == ModeRelease && diff >= thr_i) ||
                    (mode == ModeTap && diff < thr_i))) begin
          tok_d.fire[Idx]    = 1'b1;
          tok_d.held_ms[Idx] = diff;
        end
        tok_d.held[Idx]  = 1'b0;
        tok_d.fired[Idx] = 1'b0;
      end
    end
  end

  // Hand over to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = vld_q;
  assign tok_o       = tok_q;

endmodule

`default_nettype wire

@@ rtl/bchd_checker.sv @@
// Port-level checker for the hotkey detector, bound to the top level.
`default_nettype none

module bchd_checker
  import bchd_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // No new item while results wait
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while results pending");

  // An accepted item never shows a result in the next cycle
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // Non-last result is followed at once by a higher hotkey
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last |=>
      out_valid_o && (out_item_o.hotkey_index > $past(out_item_o.hotkey_index)))
    else $error("result burst broken or out of order");

  // Global results carry player zero
  a_merged_player: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.from_merged |-> out_item_o.player_index == '0)
    else $error("global result with nonzero player");

endmodule

bind button_combo_hotkey_detector_unit bchd_checker u_bchd_checker (.*);

`default_nettype wire
